FILE: rtl/core/brht_pkg.sv
package brht_pkg;

  localparam int RingDepth = 512;
  localparam int RingBits  = $clog2(RingDepth);
  localparam int CntBits   = RingBits + 1;
  localparam int CountBits = 24;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam int TimeBits  = 34;
  localparam int LevelBits = 7;
  localparam int PtsBits   = 10;
  localparam int IdleBits  = 12;
  localparam int SecBits   = 19;
  localparam int SumBits   = 22;
  localparam int DivBits   = 48;

  // floor(x / 100) == (x * CycRecip) >> CycShift for every CountBits-wide x
  localparam logic [24:0] CycRecip = 25'd21474837;
  localparam int          CycShift = 31;

  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegMin    = 2'd1;
  localparam logic [1:0] RegIdle   = 2'd2;

  typedef struct packed {
    logic [TimeBits-1:0]  sample_time;
    logic                 level_present;
    logic [LevelBits-1:0] battery_level;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        stats_valid;
    logic [17:0] cycles;
    logic        runtime_valid;
    logic [9:0]  runtime_tenths;
    logic        health_valid;
    logic [9:0]  baseline_tenths;
    logic [6:0]  health_percent;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

endpackage

FILE: rtl/core/brht_if.sv
interface brht_in_if;
  import brht_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface brht_out_if;
  import brht_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface brht_cfg_if;
  import brht_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/brht_div.sv
module brht_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [brht_pkg::DivBits-1:0] num_i,
  input  logic [brht_pkg::DivBits-1:0] den_i,
  output logic                       done_o,
  output logic [brht_pkg::DivBits-1:0] quot_o
);
  import brht_pkg::*;

  localparam int StepBits = $clog2(DivBits + 1);

  logic [DivBits-1:0]  rem_q, rem_d, quot_q, quot_d, den_q;
  logic [StepBits-1:0] step_q, step_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [DivBits:0]    trial;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[DivBits-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quot_d = num_i;
      step_d = StepBits'(DivBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivBits]) begin
        rem_d  = trial[DivBits-1:0];
        quot_d = {quot_q[DivBits-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[DivBits-2:0], quot_q[DivBits-1]};
        quot_d = {quot_q[DivBits-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

FILE: rtl/core/battery_runtime_health_tracker_unit.sv
// Battery runtime and health tracker.
// Channels: in_i carries one event (sample_time, level_present, battery_level);
// out_o carries one result per event; cfg_i writes window_points (index 0),
// min_points (1) and idle_seconds_per_point (2), with other indexes ignored.
// Sequence: one event runs through a sequencer. The update runs in StUpd and
// StWrite, the recent window is re-summed backwards through the drain memory
// (at most 512 entries), and the runtime, baseline and health figures go
// through one shared 48-bit restoring divider in turn. The result register
// loads in StOut after the event is taken; cycles comes from a reciprocal
// multiply.
// Throughput: one event at a time; in_i is ready only in the idle state with
// the result register empty, so a new event is not taken before the last
// result has been taken; the spacing depends on the window scan length.
// Reset: all counters, the ring pointers and baseline clear at once; the
// drain memory is not cleared and only written entries are read.
// Stall: the result waits in an output register; while out_o is not taken
// the next event is not started, and nothing is lost.
module battery_runtime_health_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  brht_in_if.sink     in_i,
  brht_cfg_if.sink    cfg_i,
  brht_out_if.source  out_o
);
  import brht_pkg::*;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StUpd   = 9'b000000010,
    StWrite = 9'b000000100,
    StScanA = 9'b000001000,
    StScanB = 9'b000010000,
    StDivR  = 9'b000100000,
    StDivB  = 9'b001000000,
    StDivH  = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [PtsBits-1:0]   win_q, min_q;
  logic [IdleBits-1:0]  idle_q;
  logic [LevelBits-1:0] prev_lvl_q;
  logic                 prev_vld_q, link_q;
  logic [TimeBits-1:0]  prev_time_q;
  logic [CountBits-1:0] drained_q, measured_q;
  logic [RingBits-1:0]  oldest_q;
  logic [CntBits-1:0]   count_q;
  logic [PtsBits+1:0]   base_pts_q;
  logic [SumBits+2:0]   base_sec_q;
  logic [PtsBits+1:0]   rec_pts_q;
  logic [SumBits+2:0]   rec_sec_q;

  logic [LevelBits-1:0] drop_mem [RingDepth];
  logic [SecBits-1:0]   sec_mem  [RingDepth];
  logic [LevelBits-1:0] rd_drop_q;
  logic [SecBits-1:0]   rd_sec_q;
  logic                 wr_en;
  logic [RingBits-1:0]  wr_addr, rd_addr;
  logic [CntBits-1:0]   scan_k_q;

  in_item_t             item_q;
  logic                 acc_q, store_q;
  logic [LevelBits-1:0] drop_q;
  logic [TimeBits-1:0]  dt_q;
  out_item_t            res_q;
  logic                 out_vld_q;

  logic                 div_start, div_done;
  logic [DivBits-1:0]   div_num, div_den, div_quot;

  logic [LevelBits-1:0] lvl_c;
  assign lvl_c = (item_q.battery_level > LevelBits'(100)) ? LevelBits'(100)
                                                           : item_q.battery_level;

  logic [CountBits:0] drained_sum, measured_sum;
  assign drained_sum  = {1'b0, drained_q} + (CountBits+1)'(drop_q);
  assign measured_sum = {1'b0, measured_q} + (CountBits+1)'(drop_q);

  logic [CountBits+24:0] cyc_prod;
  assign cyc_prod = drained_q * CycRecip;

  logic [TimeBits-1:0] idle_lim;
  assign idle_lim = TimeBits'(idle_q * drop_q);

  logic rt_vld, h_vld;
  assign rt_vld = prev_vld_q && rec_pts_q != '0 && rec_pts_q >= (PtsBits+2)'(min_q);
  assign h_vld  = rt_vld && measured_q >= CountBits'({win_q, 1'b0}) &&
                  base_pts_q != '0 && base_pts_q >= (PtsBits+2)'(min_q) &&
                  base_sec_q != '0;

  function automatic logic [9:0] sat10(input logic [DivBits-1:0] q);
    return (q > DivBits'(1023)) ? 10'd1023 : q[9:0];
  endfunction

  assign in_i.ready  = state_q == StIdle && !out_vld_q;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= PtsBits'(300);
      min_q  <= PtsBits'(50);
      idle_q <= IdleBits'(3600);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        RegWindow: win_q  <= cfg_i.data.data[PtsBits-1:0];
        RegMin:    min_q  <= cfg_i.data.data[PtsBits-1:0];
        RegIdle:   idle_q <= cfg_i.data.data[IdleBits-1:0];
        default: ;
      endcase
    end
  end

  assign wr_en   = state_q == StWrite && store_q && dt_q <= idle_lim;
  assign wr_addr = (count_q < CntBits'(RingDepth)) ?
                   RingBits'(oldest_q + count_q[RingBits-1:0]) : oldest_q;
  assign rd_addr = RingBits'(oldest_q + count_q[RingBits-1:0] - 1'b1
                             - scan_k_q[RingBits-1:0]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      drop_mem[wr_addr] <= drop_q;
      sec_mem[wr_addr]  <= dt_q[SecBits-1:0];
    end
    rd_drop_q <= drop_mem[rd_addr];
    rd_sec_q  <= sec_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_i.valid && in_i.ready) state_d = StUpd;
      StUpd:   state_d = StWrite;
      StWrite: state_d = StScanA;
      StScanA: state_d = (scan_k_q < count_q && rec_pts_q < (PtsBits+2)'(win_q)) ?
                         StScanB : StDivR;
      StScanB: state_d = StScanA;
      StDivR:  if (div_done) state_d = StDivB;
      StDivB:  if (div_done) state_d = StDivH;
      StDivH:  if (div_done) state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic div_arm_q;
  assign div_start = div_arm_q;

  always_comb begin
    div_num = '0;
    div_den = DivBits'(1);
    priority case (1'b1)
      state_q == StDivR: begin
        div_num = DivBits'(rec_sec_q) * DivBits'(10) + DivBits'(rec_pts_q) * DivBits'(18);
        div_den = DivBits'(rec_pts_q) * DivBits'(36);
      end
      state_q == StDivB: begin
        div_num = DivBits'(base_sec_q) * DivBits'(10) + DivBits'(base_pts_q) * DivBits'(18);
        div_den = DivBits'(base_pts_q) * DivBits'(36);
      end
      state_q == StDivH: begin
        div_num = DivBits'(DivBits'(rec_sec_q) * DivBits'(base_pts_q)) * DivBits'(200)
                  + DivBits'(rec_pts_q) * DivBits'(base_sec_q);
        div_den = DivBits'(rec_pts_q) * DivBits'(base_sec_q) * DivBits'(2);
      end
      default: ;
    endcase
    if (div_den == '0) div_den = DivBits'(1);
  end

  brht_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_lvl_q  <= '0;
      prev_vld_q  <= 1'b0;
      prev_time_q <= '0;
      link_q      <= 1'b0;
      drained_q   <= '0;
      measured_q  <= '0;
      oldest_q    <= '0;
      count_q     <= '0;
      base_pts_q  <= '0;
      base_sec_q  <= '0;
      rec_pts_q   <= '0;
      rec_sec_q   <= '0;
      scan_k_q    <= '0;
      out_vld_q   <= 1'b0;
      div_arm_q   <= 1'b0;
      acc_q       <= 1'b0;
      store_q     <= 1'b0;
      drop_q      <= '0;
      dt_q        <= '0;
      res_q       <= '0;
    end else begin
      state_q   <= state_d;
      div_arm_q <= 1'b0;
      if (out_vld_q && out_o.ready) out_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          store_q <= 1'b0;
          drop_q  <= '0;
        end
        StUpd: begin
          if (!item_q.level_present) begin
            acc_q  <= link_q;
            link_q <= 1'b0;
          end else if (link_q && prev_vld_q && prev_lvl_q == lvl_c) begin
            acc_q <= 1'b0;
          end else begin
            acc_q <= 1'b1;
            if (prev_vld_q && lvl_c < prev_lvl_q) begin
              drop_q <= prev_lvl_q - lvl_c;
              dt_q   <= item_q.sample_time - prev_time_q;
              store_q <= link_q && item_q.sample_time > prev_time_q;
            end
            prev_lvl_q  <= lvl_c;
            prev_vld_q  <= 1'b1;
            prev_time_q <= item_q.sample_time;
            link_q      <= 1'b1;
          end
        end
        StWrite: begin
          drained_q <= drained_sum[CountBits] ? CountMax : drained_sum[CountBits-1:0];
          if (store_q && dt_q <= idle_lim) begin
            if (count_q < CntBits'(RingDepth)) count_q <= count_q + 1'b1;
            else oldest_q <= oldest_q + 1'b1;
            measured_q <= measured_sum[CountBits] ? CountMax
                                                  : measured_sum[CountBits-1:0];
            if (base_pts_q < (PtsBits+2)'(win_q)) begin
              base_pts_q <= base_pts_q + (PtsBits+2)'(drop_q);
              base_sec_q <= base_sec_q + (SumBits+3)'(dt_q[SecBits-1:0]);
            end
          end
          rec_pts_q <= '0;
          rec_sec_q <= '0;
          scan_k_q  <= '0;
        end
        StScanA: begin
          if (state_d == StDivR) div_arm_q <= 1'b1;
        end
        StScanB: begin
          rec_pts_q <= rec_pts_q + (PtsBits+2)'(rd_drop_q);
          rec_sec_q <= rec_sec_q + (SumBits+3)'(rd_sec_q);
          scan_k_q  <= scan_k_q + 1'b1;
        end
        StDivR: if (div_done) begin
          res_q.runtime_tenths <= rt_vld ? sat10(div_quot) : '0;
          div_arm_q            <= 1'b1;
        end
        StDivB: if (div_done) begin
          res_q.baseline_tenths <= h_vld ? sat10(div_quot) : '0;
          div_arm_q             <= 1'b1;
        end
        StDivH: if (div_done) begin
          res_q.health_percent <= !h_vld ? '0 :
                                  (div_quot > DivBits'(100)) ? 7'd100 : div_quot[6:0];
        end
        StOut: begin
          res_q.accepted      <= acc_q;
          res_q.stats_valid   <= prev_vld_q;
          res_q.cycles        <= prev_vld_q ? cyc_prod[CycShift+17:CycShift] : '0;
          res_q.runtime_valid <= rt_vld;
          res_q.health_valid  <= h_vld;
          out_vld_q           <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) item_q <= in_i.data;
  end

  // The drain store only reads through the memory with a registered read,
  // so each scanned entry is addressed in StScanA and added in StScanB.

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(RingDepth)) else $error("ring count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_vld_q) else $error("input taken with result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> out_vld_q) else $error("result dropped");
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import brht_pkg::*;

  localparam int unsigned CycleLimit = 10000000;
  localparam int unsigned DrainCycles = 800;

  logic clk_i;
  logic rst_ni;

  brht_in_if  in_ch ();
  brht_cfg_if cfg_ch ();
  brht_out_if out_ch ();

  battery_runtime_health_tracker_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .cfg_i  (cfg_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  in_item_t  event_queue[$];
  out_item_t expected_results[$];
  int unsigned cycle_count;
  int unsigned mismatches;

  longint unsigned cfg_window, cfg_min, cfg_idle;
  longint unsigned last_level, last_time, drained, measured;
  longint unsigned ring_first, ring_fill, rec_pts, rec_secs, base_pts, base_secs;
  bit last_valid, connected;
  logic [6:0]  drop_ring[RingDepth];
  logic [18:0] secs_ring[RingDepth];

  longint unsigned gen_time, gen_level;

  function automatic longint unsigned sat_count(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > CountMax) ? CountMax : s;
  endfunction

  function automatic longint unsigned runtime_of(longint unsigned secs, longint unsigned pts);
    longint unsigned q;
    q = (10 * secs + 18 * pts) / (36 * pts);
    return (q > 1023) ? 1023 : q;
  endfunction

  function automatic void record_drain(longint unsigned drop, longint unsigned secs);
    int unsigned slot;
    if (ring_fill < RingDepth) begin
      slot = (ring_first + ring_fill) % RingDepth;
      ring_fill++;
    end else begin
      slot = ring_first % RingDepth;
      ring_first = (ring_first + 1) % RingDepth;
    end
    drop_ring[slot] = drop[6:0];
    secs_ring[slot] = secs[18:0];
    measured = sat_count(measured, drop);
    if (base_pts < cfg_window) begin
      base_pts += drop;
      base_secs += secs;
    end
  endfunction

  function automatic out_item_t health_after(in_item_t ev);
    out_item_t r;
    longint unsigned t, lvl, drop, num, den, hp;
    int unsigned slot;
    t = ev.sample_time;
    lvl = ev.battery_level;
    r = '0;
    if (lvl > 100) lvl = 100;
    if (!ev.level_present) begin
      r.accepted = connected;
      connected = 1'b0;
    end else if (connected && last_valid && last_level == lvl) begin
      r.accepted = 1'b0;
    end else begin
      r.accepted = 1'b1;
      if (last_valid && lvl < last_level) begin
        drop = last_level - lvl;
        drained = sat_count(drained, drop);
        if (connected && t > last_time && t - last_time <= cfg_idle * drop)
          record_drain(drop, t - last_time);
      end
      last_level = lvl;
      last_valid = 1'b1;
      last_time = t;
      connected = 1'b1;
    end
    rec_pts = 0;
    rec_secs = 0;
    for (longint unsigned k = 0; k < ring_fill && rec_pts < cfg_window; k++) begin
      slot = (ring_first + ring_fill - 1 - k) % RingDepth;
      rec_pts += drop_ring[slot];
      rec_secs += secs_ring[slot];
    end
    if (last_valid) begin
      r.stats_valid = 1'b1;
      r.cycles = 18'(drained / 100);
      r.runtime_valid = rec_pts > 0 && rec_pts >= cfg_min;
      if (r.runtime_valid) r.runtime_tenths = 10'(runtime_of(rec_secs, rec_pts));
      r.health_valid = r.runtime_valid && measured >= 2 * cfg_window && base_pts > 0 &&
                       base_pts >= cfg_min && base_secs > 0;
      if (r.health_valid) begin
        num = 200 * rec_secs * base_pts + rec_pts * base_secs;
        den = 2 * rec_pts * base_secs;
        hp = num / den;
        if (hp > 100) hp = 100;
        r.baseline_tenths = 10'(runtime_of(base_secs, base_pts));
        r.health_percent = 7'(hp);
      end
    end
    return r;
  endfunction

  function automatic bit quiet_now();
    return cycle_count > 30000 && cycle_count < 90000;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.insert(expected_results.size(), health_after(in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (event_queue.size() > 0 && (quiet_now() || $urandom_range(99) >= 6)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= event_queue[0];
          event_queue.delete(0);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  int unsigned hold_left;
  bit held_once;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      held_once <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!held_once && expected_results.size() > 0 && cycle_count > 8000) begin
      held_once <= 1'b1;
      hold_left <= 2500;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_now() || $urandom_range(99) >= 6;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction %p", out_ch.data);
        mismatches++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (want.accepted !== out_ch.data.accepted) begin
          $error("accepted: expected %0d actual %0d", want.accepted, out_ch.data.accepted);
          mismatches++;
        end
        if (want.stats_valid !== out_ch.data.stats_valid) begin
          $error("stats_valid: expected %0d actual %0d", want.stats_valid,
                 out_ch.data.stats_valid);
          mismatches++;
        end
        if (want.cycles !== out_ch.data.cycles) begin
          $error("cycles: expected %0d actual %0d", want.cycles, out_ch.data.cycles);
          mismatches++;
        end
        if (want.runtime_valid !== out_ch.data.runtime_valid) begin
          $error("runtime_valid: expected %0d actual %0d", want.runtime_valid,
                 out_ch.data.runtime_valid);
          mismatches++;
        end
        if (want.runtime_tenths !== out_ch.data.runtime_tenths) begin
          $error("runtime_tenths: expected %0d actual %0d", want.runtime_tenths,
                 out_ch.data.runtime_tenths);
          mismatches++;
        end
        if (want.health_valid !== out_ch.data.health_valid) begin
          $error("health_valid: expected %0d actual %0d", want.health_valid,
                 out_ch.data.health_valid);
          mismatches++;
        end
        if (want.baseline_tenths !== out_ch.data.baseline_tenths) begin
          $error("baseline_tenths: expected %0d actual %0d", want.baseline_tenths,
                 out_ch.data.baseline_tenths);
          mismatches++;
        end
        if (want.health_percent !== out_ch.data.health_percent) begin
          $error("health_percent: expected %0d actual %0d", want.health_percent,
                 out_ch.data.health_percent);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, data: value};
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      RegWindow: cfg_window = value & 16'h3FF;
      RegMin:    cfg_min    = value & 16'h3FF;
      RegIdle:   cfg_idle   = value & 16'hFFF;
      default: ;
    endcase
  endtask

  task automatic set_phase(int unsigned win, int unsigned mn, int unsigned idle);
    @(posedge clk_i);
    write_reg(RegWindow, 16'(win));
    write_reg(RegMin, 16'(mn));
    write_reg(RegIdle, 16'(idle));
    write_reg(2'd3, 16'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_event(longint unsigned t, bit present, int unsigned lvl);
    in_item_t ev;
    ev.sample_time = t[TimeBits-1:0];
    ev.level_present = present;
    ev.battery_level = lvl[6:0];
    event_queue.insert(event_queue.size(), ev);
  endtask

  task automatic push_random(int unsigned n);
    int unsigned roll, drop;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        push_event(gen_time, 1'b0, $urandom_range(127));
      end else if (roll < 7) begin
        push_event(gen_time, 1'b1, gen_level);
      end else if (roll < 9) begin
        gen_time = {$urandom, $urandom} & 64'h3_FFFF_FFFF;
        push_event(gen_time, 1'b1, gen_level);
      end else if (roll < 11) begin
        gen_level = 100;
        push_event(gen_time, 1'b1, $urandom_range(101, 127));
      end else if (roll < 13) begin
        gen_time = gen_time - $urandom_range(0, 50);
        gen_level = (gen_level > 0) ? gen_level - 1 : 0;
        push_event(gen_time, 1'b1, gen_level);
      end else if (gen_level < 4 || roll < 16) begin
        gen_level = $urandom_range(gen_level, 100);
        gen_time += $urandom_range(1, 9000);
        push_event(gen_time, 1'b1, gen_level);
      end else begin
        drop = $urandom_range(1, 3);
        gen_level -= drop;
        if ($urandom_range(9) == 0) gen_time += cfg_idle * drop + $urandom_range(1, 3);
        else gen_time += $urandom_range(1, cfg_idle * drop);
        push_event(gen_time, 1'b1, gen_level);
      end
      gen_time &= 64'h3_FFFF_FFFF;
    end
  endtask

  task automatic await_idle();
    while (event_queue.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    cfg_window = 300; cfg_min = 50; cfg_idle = 3600;
    last_level = 0; last_valid = 0; last_time = 0; connected = 0;
    drained = 0; measured = 0; ring_first = 0; ring_fill = 0;
    rec_pts = 0; rec_secs = 0; base_pts = 0; base_secs = 0;
    cycle_count = 0;
    mismatches = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_event(100, 1'b0, 0);
    push_event(200, 1'b1, 127);
    push_event(300, 1'b1, 100);
    push_event(400, 1'b1, 90);
    push_event(400, 1'b1, 80);
    push_event(350, 1'b1, 70);
    push_event(50000, 1'b1, 69);
    push_event(50100, 1'b0, 69);
    push_event(50200, 1'b0, 12);
    push_event(50300, 1'b1, 69);
    push_event(50400, 1'b1, 40);
    push_event(64'h3_FFFF_FFFF, 1'b1, 0);
    push_event(64'h3_FFFF_FFFF, 1'b1, 100);
    push_event(0, 1'b1, 100);
    gen_time = 1000;
    gen_level = 100;
    push_event(gen_time, 1'b1, gen_level);
    await_idle();

    set_phase(1, 1, 1);
    push_random(200);
    await_idle();
    set_phase(20, 5, 4095);
    push_random(220);
    await_idle();
    set_phase(300, 50, 3600);
    push_random(230);
    await_idle();
    set_phase(512, 512, 3600);
    push_random(200);
    await_idle();
    set_phase(64, 10, 600);
    push_random(230);
    await_idle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
